@@ rtl/core/ptts_pkg.sv @@
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 3;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] TICK_RESET = 8'd32;

  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_INSTALL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic              present;
    logic              running;
    logic [BYTE_W-1:0] period;
    logic [BYTE_W-1:0] countdown;
  } slot_entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    slot_entry_t        entry;
  } mem_wr_t;

endpackage

@@ rtl/core/ptts_ifs.sv @@
`timescale 1ns / 1ps

interface ptts_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [ptts_pkg::SLOT_W-1:0]  slot;
  logic                         slot_valid;
  logic                         running;
  logic [ptts_pkg::BYTE_W-1:0]  period;
  logic [ptts_pkg::BYTE_W-1:0]  initial_delay;

  modport source (output valid, output operation, output slot, output slot_valid,
                  output running, output period, output initial_delay, input ready);
  modport sink (input valid, input operation, input slot, input slot_valid,
                input running, input period, input initial_delay, output ready);
endinterface

interface ptts_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptts_pkg::SLOT_W-1:0]  fired_slot;
  logic                         last;

  modport source (output valid, output fired_slot, output last, input ready);
  modport sink (input valid, input fired_slot, input last, output ready);
endinterface

interface ptts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ptts_pkg::BYTE_W-1:0]  overflows_per_tick;

  modport source (output valid, output overflows_per_tick, input ready);
  modport sink (input valid, input overflows_per_tick, output ready);
endinterface

@@ rtl/core/periodic_task_tick_scheduler_core.sv @@
`timescale 1ns / 1ps
// install and non-ticking overflow items: accepted back to back, only in idle
// a tick reads the slot table, one slot table read per cycle while the result
// register is not stalled, through a registered read, then one flush state
// fire events leave through a result register, at most one transfer per cycle
// synchronous active-low reset: empty slot table, prescaler 0, tick count 32
module periodic_task_tick_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  ptts_in_if.sink    in_ch,
  ptts_out_if.source out_ch,
  ptts_cfg_if.sink   cfg_ch
);
  import ptts_pkg::*;

  localparam logic [SLOT_AW:0] SCAN_END = (SLOT_AW + 1)'(NUM_SLOTS);

  state_t              state_r, state_nxt;
  logic [BYTE_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [BYTE_W-1:0]   tick_cfg_r;
  logic [SLOT_AW:0]    rd_idx_r, rd_idx_nxt;
  logic                proc_valid_r, proc_valid_nxt;
  logic [SLOT_AW-1:0]  proc_slot_r, proc_slot_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [SLOT_AW-1:0]  pend_slot_r, pend_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic                out_free;
  logic                active;
  logic                fire;
  logic                stall;
  logic                rd_en;
  logic [SLOT_AW-1:0]  rd_addr;
  slot_entry_t         rd_entry;
  mem_wr_t             wr;

  ptts_slot_table u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.fired_slot = out_slot_r;
  assign out_ch.last       = out_last_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign active   = proc_valid_r && rd_entry.present && rd_entry.running;
  assign fire     = active && (rd_entry.countdown == '0);
  assign stall    = fire && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    tick_cnt_nxt   = tick_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    proc_valid_nxt = proc_valid_r;
    proc_slot_nxt  = proc_slot_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[SLOT_AW-1:0];
    wr             = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_INSTALL) begin
            if (int'(in_ch.slot) < NUM_SLOTS) begin
              wr.en              = 1'b1;
              wr.addr            = SLOT_AW'(in_ch.slot);
              wr.entry.present   = in_ch.slot_valid;
              wr.entry.running   = in_ch.running;
              wr.entry.period    = in_ch.period;
              wr.entry.countdown = in_ch.initial_delay;
            end
          end else begin
            tick_cnt_nxt = tick_cnt_r + 8'd1;
            if (tick_cnt_nxt == tick_cfg_r) begin
              tick_cnt_nxt = '0;
              rd_idx_nxt   = '0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          proc_valid_nxt = 1'b0;
          if (rd_idx_r != SCAN_END) begin
            rd_en          = 1'b1;
            rd_idx_nxt     = rd_idx_r + 1'b1;
            proc_valid_nxt = 1'b1;
            proc_slot_nxt  = rd_idx_r[SLOT_AW-1:0];
          end else begin
            state_nxt = ST_FLUSH;
          end
          if (active) begin
            wr.en    = 1'b1;
            wr.addr  = proc_slot_r;
            wr.entry = rd_entry;
            wr.entry.countdown = fire ? (rd_entry.period - 8'd1)
                                      : (rd_entry.countdown - 8'd1);
          end
          // previous fire is not the last one of this tick
          if (fire) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = SLOT_W'(pend_slot_r);
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = proc_slot_r;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SLOT_W'(pend_slot_r);
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_cnt_r   <= '0;
      tick_cfg_r   <= TICK_RESET;
      proc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      proc_valid_r <= proc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tick_cfg_r <= cfg_ch.overflows_per_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    proc_slot_r <= proc_slot_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!pend_valid_r && !proc_valid_r))
    else $error("pending fire or slot in flight while idle");

  a_stall_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && stall) |=> ($stable(rd_idx_r) && $stable(proc_slot_r)))
    else $error("scan advanced during output stall");

  a_last_closes_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !$past(out_valid_r)) |-> !pend_valid_r)
    else $error("final fire event issued with another fire still pending");
`endif

endmodule

@@ rtl/core/ptts_slot_table.sv @@
`timescale 1ns / 1ps

module ptts_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ptts_pkg::SLOT_AW-1:0]  rd_addr,
  output ptts_pkg::slot_entry_t         rd_entry,
  input  ptts_pkg::mem_wr_t             wr
);
  import ptts_pkg::*;

  slot_entry_t            slot_mem_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   vld_r;
  slot_entry_t            rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_mem_r[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

  // entries never written read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

@@ bench/periodic_task_tick_scheduler_core_test.sv @@
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core_test;
  import ptts_pkg::*;

  localparam int SETTLE_CYCLES = 2 * (NUM_SLOTS + 3);
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic              running;
    logic [BYTE_W-1:0] period;
    logic [BYTE_W-1:0] initial_delay;
  } task_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } fire_event_t;

  typedef enum logic { ROW_ITEM, ROW_TICKCNT } row_kind_t;

  // tick count rows carry the new count in the period column
  typedef struct {
    row_kind_t         kind;
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic              sweep;
    logic              slot_valid;
    logic              running;
    logic [BYTE_W-1:0] period;
    logic [BYTE_W-1:0] initial_delay;
    int                reps;
    logic              typed;
    logic [NUM_SLOTS-1:0] fire_mask;
  } script_row_t;

  typedef struct {
    logic [BYTE_W-1:0] tick_count;
    int                min_items;
    int                min_ticks;
    logic              pressure;
  } phase_t;

  script_row_t script [23] = '{
    '{ROW_ITEM,    OP_INSTALL,  3'd0, 1'b0, 1'b1, 1'b1, 8'd1,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   31, 1'b1, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h01},
    '{ROW_TICKCNT, OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd1,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h01},
    '{ROW_ITEM,    OP_INSTALL,  3'd7, 1'b0, 1'b1, 1'b1, 8'd0,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd3, 1'b0, 1'b0, 1'b1, 8'd5,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd4, 1'b0, 1'b1, 1'b0, 8'd2,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h81},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h01},
    '{ROW_ITEM,    OP_INSTALL,  3'd1, 1'b0, 1'b1, 1'b1, 8'd255, 8'd255, 1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd2, 1'b0, 1'b1, 1'b1, 8'd2,   8'd1,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h01},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'h05},
    '{ROW_ITEM,    OP_INSTALL,  3'd5, 1'b0, 1'b1, 1'b1, 8'd3,   8'd2,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd6, 1'b0, 1'b1, 1'b1, 8'd0,   8'd255, 1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   3,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd0, 1'b1, 1'b1, 1'b1, 8'd1,   8'd0,   8,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'hff},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'hff},
    '{ROW_ITEM,    OP_INSTALL,  3'd3, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_INSTALL,  3'd5, 1'b0, 1'b1, 1'b0, 8'd7,   8'd0,   1,  1'b0, 8'h00},
    '{ROW_ITEM,    OP_OVERFLOW, 3'd0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   1,  1'b1, 8'hd7}
  };

  phase_t phases [6] = '{
    '{8'd1,   40, 0, 1'b1},
    '{8'd2,   20, 2, 1'b0},
    '{8'd3,   20, 2, 1'b0},
    '{8'd17,  40, 3, 1'b0},
    '{8'd255, 10, 0, 1'b0},
    '{8'd0,   10, 0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ptts_in_if  in_ch();
  ptts_out_if out_ch();
  ptts_cfg_if cfg_ch();

  periodic_task_tick_scheduler_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [NUM_SLOTS-1:0] sched_present = '0;
  logic [NUM_SLOTS-1:0] sched_running = '0;
  logic [BYTE_W-1:0]    sched_period [NUM_SLOTS] = '{default: '0};
  logic [BYTE_W-1:0]    sched_countdown [NUM_SLOTS] = '{default: '0};
  logic [BYTE_W-1:0]    sched_prescale = '0;
  logic [BYTE_W-1:0]    sched_tick_count = TICK_RESET;
  int                   tick_total = 0;

  fire_event_t due_q [$];
  int          errors = 0;
  logic        idle_on = 1'b1;
  int          hold_req = 0;

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [NUM_SLOTS-1:0] advance_schedule(input task_item_t it);
    logic [NUM_SLOTS-1:0] fired;
    fired = '0;
    if (it.operation == OP_INSTALL) begin
      if (int'(it.slot) < NUM_SLOTS) begin
        sched_present[it.slot]   = it.slot_valid;
        sched_running[it.slot]   = it.running;
        sched_period[it.slot]    = it.period;
        sched_countdown[it.slot] = it.initial_delay;
      end
    end else begin
      sched_prescale = sched_prescale + 8'd1;
      if (sched_prescale == sched_tick_count) begin
        sched_prescale = '0;
        tick_total++;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (sched_present[s] && sched_running[s]) begin
            if (sched_countdown[s] == 8'd0) begin
              fired[s] = 1'b1;
              sched_countdown[s] = sched_period[s] - 8'd1;
            end else begin
              sched_countdown[s] = sched_countdown[s] - 8'd1;
            end
          end
        end
      end
    end
    return fired;
  endfunction

  task automatic queue_fires(input logic [NUM_SLOTS-1:0] mask);
    int left;
    fire_event_t ev;
    left = $countones(mask);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (mask[s]) begin
        left--;
        ev.slot = SLOT_W'(s);
        ev.last = (left == 0);
        due_q.push_back(ev);
      end
    end
  endtask

  task automatic send_item(input task_item_t it, input logic typed,
                           input logic [NUM_SLOTS-1:0] typed_mask);
    int gap;
    logic [NUM_SLOTS-1:0] fired;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= it.operation;
    in_ch.slot          <= it.slot;
    in_ch.slot_valid    <= it.slot_valid;
    in_ch.running       <= it.running;
    in_ch.period        <= it.period;
    in_ch.initial_delay <= it.initial_delay;
    do @(posedge clk); while (!in_ch.ready);
    fired = advance_schedule(it);
    queue_fires(typed ? typed_mask : fired);
  endtask

  // only while idle: results drained and any silent tick finished
  task automatic set_tick_count(input logic [BYTE_W-1:0] value);
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid              <= 1'b1;
    cfg_ch.overflows_per_tick <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sched_tick_count = value;
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_req) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) < 2) stall_left = gap_length();
      end
    end
  end

  initial begin : result_check
    fire_event_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: fire event with none due, slot %0d last %0b",
                   $time, out_ch.fired_slot, out_ch.last);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_ch.fired_slot !== want.slot) begin
            $display("%0t: fired_slot expected %0d actual %0d",
                     $time, want.slot, out_ch.fired_slot);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    task_item_t it;
    int         n;
    int         ticks_at_start;
    int         overflow_pct;
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.operation           <= OP_OVERFLOW;
    in_ch.slot                <= '0;
    in_ch.slot_valid          <= 1'b0;
    in_ch.running             <= 1'b0;
    in_ch.period              <= '0;
    in_ch.initial_delay       <= '0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.overflows_per_tick <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_TICKCNT) begin
        in_ch.valid <= 1'b0;
        set_tick_count(script[i].period);
      end else begin
        for (int r = 0; r < script[i].reps; r++) begin
          it.operation     = script[i].operation;
          it.slot          = script[i].sweep ? script[i].slot + SLOT_W'(r) : script[i].slot;
          it.slot_valid    = script[i].slot_valid;
          it.running       = script[i].running;
          it.period        = script[i].period;
          it.initial_delay = script[i].initial_delay;
          send_item(it, script[i].typed, script[i].fire_mask);
        end
      end
    end
    in_ch.valid <= 1'b0;

    foreach (phases[p]) begin
      set_tick_count(phases[p].tick_count);
      idle_on = (p % 3 != 2);
      if (phases[p].pressure) hold_req++;
      overflow_pct = (phases[p].tick_count == 8'd0 || phases[p].tick_count > 8'd8) ? 97 : 55;
      n = 0;
      ticks_at_start = tick_total;
      while (n < phases[p].min_items || tick_total - ticks_at_start < phases[p].min_ticks) begin
        it.operation     = ($urandom_range(0, 99) < overflow_pct) ? OP_OVERFLOW : OP_INSTALL;
        it.slot          = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        it.slot_valid    = ($urandom_range(0, 4) != 0);
        it.running       = ($urandom_range(0, 4) != 0);
        it.period        = ($urandom_range(0, 9) < 7) ? BYTE_W'($urandom_range(0, 4))
                                                      : BYTE_W'($urandom_range(0, 255));
        it.initial_delay = ($urandom_range(0, 9) < 7) ? BYTE_W'($urandom_range(0, 3))
                                                      : BYTE_W'($urandom_range(0, 255));
        send_item(it, 1'b0, '0);
        n++;
      end
      in_ch.valid <= 1'b0;
    end

    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
